// ----- design/mdvs_pkg.sv -----
// ----------------------------------------------------------------------------
// mdvs_pkg
// Shared widths, register indexes and divider handshake types for the
// median divider voltage scaler.
// ----------------------------------------------------------------------------
package mdvs_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned OHM_W      = 20;
  localparam int unsigned CAL_W      = 16;
  localparam int unsigned PACK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned SUM_W   = OHM_W + 1;             // top + bottom
  localparam int unsigned PROD1_W = SAMPLE_W + SUM_W;      // pin * (top + bottom)
  localparam int unsigned DIV_DW  = PROD1_W + CAL_W;       // widest dividend
  localparam int unsigned DIV_VW  = OHM_W;                 // widest divisor
  localparam int unsigned DIV_CW  = $clog2(DIV_DW);

  localparam logic [PACK_W-1:0] PACK_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_SENSE_READY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_BOTTOM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_NUM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_DEN     = 3'd4;

  localparam logic [OHM_W-1:0] DIV_TOP_RST    = 20'd100000;
  localparam logic [OHM_W-1:0] DIV_BOTTOM_RST = 20'd20000;
  localparam logic [CAL_W-1:0] CAL_NUM_RST    = 16'd1;
  localparam logic [CAL_W-1:0] CAL_DEN_RST    = 16'd1;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/mdvs_cell.sv -----
// ----------------------------------------------------------------------------
// mdvs_cell
// One slot of the sorted sample chain. On insert it takes its left
// neighbor's value, the new sample, or keeps its own.
// ----------------------------------------------------------------------------
module mdvs_cell (
  input  logic                          clk_i,
  input  logic                          ins_i,
  input  logic                          occ_i,
  input  logic [mdvs_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          prev_gt_i,
  input  logic [mdvs_pkg::SAMPLE_W-1:0] prev_val_i,
  output logic [mdvs_pkg::SAMPLE_W-1:0] val_o,
  output logic                          gt_o
);
  import mdvs_pkg::*;

  logic [SAMPLE_W-1:0] val_q, val_d;

  // empty slot acts as +inf
  assign gt_o  = !occ_i || (val_q > sample_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ins_i) begin
      if (prev_gt_i) begin
        val_d = prev_val_i;
      end else if (gt_o) begin
        val_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ----- design/mdvs_divider.sv -----
// ----------------------------------------------------------------------------
// mdvs_divider
// Bit-serial restoring divider, one quotient bit per cycle, shared by both
// scaling steps.
// ----------------------------------------------------------------------------
module mdvs_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mdvs_pkg::div_req_t req_i,
  output mdvs_pkg::div_rsp_t rsp_o
);
  import mdvs_pkg::*;

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_VW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] quo_q, quo_d;
  logic [DIV_VW-1:0] dvs_q, dvs_d;

  logic [DIV_VW:0]   trial;
  logic [DIV_VW:0]   diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DIV_DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = req_i.dividend;
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      rem_d = ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
      quo_d = {quo_q[DIV_DW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_DW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- design/median_divider_voltage_scaler.sv -----
// ----------------------------------------------------------------------------
// median_divider_voltage_scaler
// Sorted insertion chain of sample cells; each full window takes the median,
// scales it by (top+bottom)/bottom and cal_num/cal_den, clamps to 16 bits.
// ----------------------------------------------------------------------------
//  channel  | signals                                | handshake
//  ---------+----------------------------------------+-------------------------
//  sample   | start_i, busy_o, sample_mv_i           | start_i && !busy_o
//  result   | done_o, pack_mv_o, clamped_o           | done_o, one cycle
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i       | cfg_we_i
//
//  A sample that does not close the window is inserted as it is accepted; busy_o
//  stays low. A word when not ready comes out the next cycle as zero.
//  The sample closing the window keeps busy_o high through the median, two
//  operand loads and two passes of the shared bit-serial divider, each a
//  quotient step per dividend bit plus done; the word shows as busy_o drops.
//  With a zero divisor busy_o is high one cycle and the word follows.
//  Reset clears the window count and loads the register reset values.
//  The receiver cannot stall; each result word is shown for one cycle.
// ----------------------------------------------------------------------------
module median_divider_voltage_scaler #(
  parameter int unsigned WINDOW_SAMPLES = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [mdvs_pkg::SAMPLE_W-1:0]   sample_mv_i,
  output logic                            done_o,
  output logic [mdvs_pkg::PACK_W-1:0]     pack_mv_o,
  output logic                            clamped_o,
  input  logic                            cfg_we_i,
  input  logic [mdvs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mdvs_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mdvs_pkg::*;

  localparam int unsigned CNT_W  = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned MID_LO = WINDOW_SAMPLES / 2 - 1;
  localparam int unsigned MID_HI = WINDOW_SAMPLES / 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MED  = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_DIV1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_DIV2 = 3'd5;

  logic             ready_q;
  logic [OHM_W-1:0] top_q;
  logic [OHM_W-1:0] bot_q;
  logic [CAL_W-1:0] num_q;
  logic [CAL_W-1:0] den_q;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              done_q, done_d;
  logic [PACK_W-1:0] pack_q, pack_d;
  logic              clamped_q, clamped_d;
  logic [SAMPLE_W-1:0] pin_q, pin_d;

  logic accept;
  logic insert;

  logic [SAMPLE_W-1:0] val_w [WINDOW_SAMPLES];
  logic                gt_w  [WINDOW_SAMPLES];

  logic [SUM_W-1:0]   ohm_sum;
  logic [PROD1_W-1:0] prod1;
  logic [DIV_DW-1:0]  prod2;
  logic [SAMPLE_W:0]  mid_sum;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept = start_i && !busy_o;
  assign insert = accept && ready_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      top_q   <= DIV_TOP_RST;
      bot_q   <= DIV_BOTTOM_RST;
      num_q   <= CAL_NUM_RST;
      den_q   <= CAL_DEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SENSE_READY: ready_q <= cfg_wdata_i[0];
        REG_DIV_TOP:     top_q   <= cfg_wdata_i[OHM_W-1:0];
        REG_DIV_BOTTOM:  bot_q   <= cfg_wdata_i[OHM_W-1:0];
        REG_CAL_NUM:     num_q   <= cfg_wdata_i[CAL_W-1:0];
        REG_CAL_DEN:     den_q   <= cfg_wdata_i[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  // sorted chain
  for (genvar i = 0; i < WINDOW_SAMPLES; i++) begin : g_cell
    logic                occ;
    logic                prev_gt;
    logic [SAMPLE_W-1:0] prev_val;

    assign occ = CNT_W'(i) < count_q;
    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_body
      assign prev_gt  = gt_w[i-1];
      assign prev_val = val_w[i-1];
    end

    mdvs_cell u_cell (
      .clk_i      (clk_i),
      .ins_i      (insert),
      .occ_i      (occ),
      .sample_i   (sample_mv_i),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .val_o      (val_w[i]),
      .gt_o       (gt_w[i])
    );
  end

  assign mid_sum = {1'b0, val_w[MID_LO]} + {1'b0, val_w[MID_HI]};
  assign ohm_sum = {1'b0, top_q} + {1'b0, bot_q};
  assign prod1   = PROD1_W'(pin_q) * PROD1_W'(ohm_sum);
  assign prod2   = DIV_DW'(div_rsp.quotient[PROD1_W-1:0]) * DIV_DW'(num_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    done_d    = 1'b0;
    pack_d    = pack_q;
    clamped_d = clamped_q;
    pin_d     = pin_q;
    div_req   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!ready_q) begin
            done_d    = 1'b1;
            pack_d    = '0;
            clamped_d = 1'b0;
          end else if (count_q == CNT_W'(WINDOW_SAMPLES - 1)) begin
            count_d = '0;
            state_d = ST_MED;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      ST_MED: begin
        pin_d = mid_sum[SAMPLE_W:1];
        if (bot_q == '0 || den_q == '0) begin
          done_d    = 1'b1;
          pack_d    = PACK_MAX;
          clamped_d = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_DW'(prod1);
        div_req.divisor  = bot_q;
        state_d          = ST_DIV1;
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod2;
        div_req.divisor  = DIV_VW'(den_q);
        state_d          = ST_DIV2;
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (|div_rsp.quotient[DIV_DW-1:PACK_W]) begin
            pack_d    = PACK_MAX;
            clamped_d = 1'b1;
          end else begin
            pack_d    = div_rsp.quotient[PACK_W-1:0];
            clamped_d = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  mdvs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pack_q    <= pack_d;
    clamped_q <= clamped_d;
    pin_q     <= pin_d;
  end

  assign busy_o    = state_q != ST_IDLE;
  assign done_o    = done_q;
  assign pack_mv_o = pack_q;
  assign clamped_o = clamped_q;

  a_not_ready_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ready_q) |=> (done_o && pack_mv_o == '0 && !clamped_o))
    else $error("not-ready word did not give a zero result");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CNT_W'(WINDOW_SAMPLES))
    else $error("window count overran the window");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
    else $error("divider finished outside a divide step");

  a_clamp_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clamped_o) |-> pack_mv_o == PACK_MAX)
    else $error("clamped word not at full scale");

endmodule
